FILE: rtl/fat_chain_allocator_assert.svh
// Assertion macros used by the allocator engine.
`ifndef FAT_CHAIN_ALLOCATOR_ASSERT_SVH
`define FAT_CHAIN_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FCA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fca assertion failed");

// Next-cycle implication, disabled during reset.
`define FCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fca assertion failed");

`endif

FILE: rtl/fca_pkg.sv
// Shared types and constants of the block chain allocator.
`default_nettype none
package fca_pkg;

   localparam int FIELD_W          = 13;
   localparam int DEF_NUM_BLOCKS   = 4096;
   localparam int REQ_TDATA_W      = 32;
   localparam int RSP_TDATA_W      = 56;
   localparam int REQ_TUSER_W      = 2;

   typedef enum logic [1:0] {
      CMD_ALLOC  = 2'd0,
      CMD_FREE   = 2'd1,
      CMD_LOOKUP = 2'd2
   } cmd_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
      logic wr_free;
   } tbl_ctl_type;

endpackage
`default_nettype wire

FILE: rtl/fca_alu.sv
// Shared add/subtract and less-than unit used by the sequencer.
`default_nettype none
module fca_alu #(
   parameter int AW = fca_pkg::FIELD_W
) (
   input  fca_pkg::alu_op_type op,
   input  logic [AW-1:0]       a,
   input  logic [AW-1:0]       b,
   input  logic [AW-1:0]       c,
   output logic [AW-1:0]       sum,
   output logic                lt
);
   import fca_pkg::*;

   always_comb begin
      case (op)
         ALU_ADD: sum = a + b;
         ALU_SUB: sum = a - b;
         default: sum = a + b;
      endcase
      lt = (sum < c);
   end

endmodule
`default_nettype wire

FILE: rtl/fca_table.sv
// Link table and free map memory with a clearing sweep after reset.
`default_nettype none
module fca_table #(
   parameter int NUM_BLOCKS = fca_pkg::DEF_NUM_BLOCKS,
   parameter int IDX_W      = $clog2(NUM_BLOCKS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  fca_pkg::tbl_ctl_type  ctl,
   input  logic [IDX_W-1:0]      wr_addr,
   input  logic [IDX_W:0]        wr_link,
   input  logic [IDX_W-1:0]      rd_addr,
   output logic                  rd_free,
   output logic [IDX_W:0]        rd_link,
   output logic                  clearing
);
   import fca_pkg::*;

   localparam int EW = IDX_W + 2;
   localparam logic [IDX_W:0] LINK_NONE = {1'b1, {IDX_W{1'b0}}};
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

   logic [EW-1:0]    mem [NUM_BLOCKS];
   logic [EW-1:0]    rd_data_ff;
   logic             clr_busy_ff, clr_busy_in;
   logic [IDX_W-1:0] clr_idx_ff, clr_idx_in;
   logic             we;
   logic [IDX_W-1:0] waddr;
   logic [EW-1:0]    wdata;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_idx_in  = clr_idx_ff;
      if (clr_busy_ff) begin
         clr_idx_in = clr_idx_ff + IDX_W'(1);
         if (clr_idx_ff == LAST_IDX) begin
            clr_busy_in = 1'b0;
         end
      end
      we    = clr_busy_ff | ctl.wr_en;
      waddr = clr_busy_ff ? clr_idx_ff : wr_addr;
      wdata = clr_busy_ff ? {1'b1, LINK_NONE} : {ctl.wr_free, wr_link};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_free  = rd_data_ff[EW-1];
   assign rd_link  = rd_data_ff[IDX_W:0];
   assign clearing = clr_busy_ff;

endmodule
`default_nettype wire

FILE: rtl/fca_engine.sv
// Command sequencer: allocate scan, free walk and link lookup.
`default_nettype none
module fca_engine #(
   parameter int NUM_BLOCKS = fca_pkg::DEF_NUM_BLOCKS,
   parameter int IDX_W      = $clog2(NUM_BLOCKS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   output logic                          cmd_ready,
   input  logic [1:0]                    command,
   input  logic [fca_pkg::FIELD_W-1:0]   block_count,
   input  logic [fca_pkg::FIELD_W-1:0]   chain_head,
   output fca_pkg::tbl_ctl_type          ctl,
   output logic [IDX_W-1:0]              tbl_addr,
   output logic [IDX_W:0]                wr_link,
   input  logic                          rd_free,
   input  logic [IDX_W:0]                rd_link,
   input  logic                          clearing,
   output logic                          res_valid,
   input  logic                          res_ready,
   output logic                          status,
   output logic [fca_pkg::FIELD_W-1:0]   new_head,
   output logic [fca_pkg::FIELD_W-1:0]   done_count,
   output logic [fca_pkg::FIELD_W-1:0]   link_value,
   output logic [fca_pkg::FIELD_W-1:0]   free_total
);
   import fca_pkg::*;
   `include "fat_chain_allocator_assert.svh"

   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
   localparam int AW    = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;
   localparam int HW    = (IDX_W > FIELD_W) ? IDX_W : FIELD_W;
   localparam logic [IDX_W:0]     LINK_NONE = {1'b1, {IDX_W{1'b0}}};
   localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(NUM_BLOCKS - 1);
   localparam logic [FIELD_W-1:0] FIELD_NONE = {FIELD_W{1'b1}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ALLOC_RD,
      ST_ALLOC_EX,
      ST_FREE_RD,
      ST_FREE_EX,
      ST_LOOK_RD,
      ST_LOOK_EX,
      ST_FINISH,
      ST_RESULT
   } state_type;

   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [FIELD_W-1:0] want_ff, want_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W:0]   prev_ff, prev_in;
   logic [IDX_W:0]   link_ff, link_in;
   logic [CNT_W-1:0] done_ff, done_in;
   logic [CNT_W-1:0] free_cnt_ff, free_cnt_in;
   logic             status_ff, status_in;

   alu_op_type       alu_op;
   logic [AW-1:0]    alu_a, alu_b, alu_c, alu_sum;
   logic             alu_lt;

   logic             head_ok;
   logic [HW-1:0]    head_x;
   logic [IDX_W-1:0] head_idx;
   logic [HW-1:0]    prev_x, link_x;
   logic [AW-1:0]    done_x, free_x;

   fca_alu #(.AW(AW)) u_alu (
      .op  (alu_op),
      .a   (alu_a),
      .b   (alu_b),
      .c   (alu_c),
      .sum (alu_sum),
      .lt  (alu_lt)
   );

   assign head_ok  = !chain_head[FIELD_W-1] &&
                     (32'(chain_head) < 32'(NUM_BLOCKS));
   assign head_x   = HW'(chain_head);
   assign head_idx = head_x[IDX_W-1:0];

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      want_in     = want_ff;
      idx_in      = idx_ff;
      prev_in     = prev_ff;
      link_in     = link_ff;
      done_in     = done_ff;
      free_cnt_in = free_cnt_ff;
      status_in   = status_ff;
      ctl         = '0;
      tbl_addr    = idx_ff;
      wr_link     = prev_ff;
      alu_op      = ALU_ADD;
      alu_a       = AW'(done_ff);
      alu_b       = AW'(1);
      alu_c       = AW'(want_ff);
      cmd_ready   = (state_ff == ST_IDLE) && !clearing;
      res_valid   = (state_ff == ST_RESULT);

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && cmd_ready) begin
               cmd_in    = cmd_type'(command);
               want_in   = block_count;
               done_in   = '0;
               prev_in   = LINK_NONE;
               link_in   = LINK_NONE;
               status_in = 1'b0;
               idx_in    = '0;
               case (command)
                  CMD_ALLOC: begin
                     state_in = (block_count == '0) ? ST_FINISH : ST_ALLOC_RD;
                  end
                  CMD_FREE: begin
                     idx_in    = head_idx;
                     status_in = !head_ok;
                     state_in  = head_ok ? ST_FREE_RD : ST_FINISH;
                  end
                  CMD_LOOKUP: begin
                     idx_in    = head_idx;
                     status_in = !head_ok;
                     state_in  = head_ok ? ST_LOOK_RD : ST_FINISH;
                  end
                  default: begin
                     status_in = 1'b1;
                     state_in  = ST_FINISH;
                  end
               endcase
            end
         end
         ST_ALLOC_RD: begin
            ctl.rd_en = 1'b1;
            state_in  = ST_ALLOC_EX;
         end
         ST_ALLOC_EX: begin
            if (rd_free) begin
               ctl.wr_en   = 1'b1;
               ctl.wr_free = 1'b0;
               wr_link     = prev_ff;
               prev_in     = {1'b0, idx_ff};
               done_in     = alu_sum[CNT_W-1:0];
            end
            if ((idx_ff == LAST_IDX) || (rd_free && !alu_lt)) begin
               status_in = rd_free ? alu_lt : 1'b1;
               state_in  = ST_FINISH;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_ALLOC_RD;
            end
         end
         ST_FREE_RD: begin
            ctl.rd_en = 1'b1;
            state_in  = ST_FREE_EX;
         end
         ST_FREE_EX: begin
            ctl.wr_en   = 1'b1;
            ctl.wr_free = 1'b1;
            wr_link     = LINK_NONE;
            if (!rd_free) begin
               done_in = alu_sum[CNT_W-1:0];
            end
            if (rd_link[IDX_W]) begin
               state_in = ST_FINISH;
            end else begin
               idx_in   = rd_link[IDX_W-1:0];
               state_in = ST_FREE_RD;
            end
         end
         ST_LOOK_RD: begin
            ctl.rd_en = 1'b1;
            state_in  = ST_LOOK_EX;
         end
         ST_LOOK_EX: begin
            link_in  = rd_link;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            alu_a       = AW'(free_cnt_ff);
            alu_b       = AW'(done_ff);
            alu_op      = (cmd_ff == CMD_FREE) ? ALU_ADD : ALU_SUB;
            free_cnt_in = alu_sum[CNT_W-1:0];
            state_in    = ST_RESULT;
         end
         ST_RESULT: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         free_cnt_ff <= CNT_W'(NUM_BLOCKS);
      end else begin
         state_ff    <= state_in;
         free_cnt_ff <= free_cnt_in;
      end
      cmd_ff    <= cmd_in;
      want_ff   <= want_in;
      idx_ff    <= idx_in;
      prev_ff   <= prev_in;
      link_ff   <= link_in;
      done_ff   <= done_in;
      status_ff <= status_in;
   end

   assign prev_x = HW'(prev_ff[IDX_W-1:0]);
   assign link_x = HW'(link_ff[IDX_W-1:0]);
   assign done_x = AW'(done_ff);
   assign free_x = AW'(free_cnt_ff);

   assign status     = status_ff;
   assign new_head   = prev_ff[IDX_W] ? FIELD_NONE : prev_x[FIELD_W-1:0];
   assign link_value = link_ff[IDX_W] ? FIELD_NONE : link_x[FIELD_W-1:0];
   assign done_count = done_x[FIELD_W-1:0];
   assign free_total = free_x[FIELD_W-1:0];

   `FCA_ASSERT_NOW(a_idle_while_clearing, clock, reset, clearing, state_ff == ST_IDLE)
   `FCA_ASSERT_NOW(a_free_cnt_range, clock, reset, 1'b1,
                   free_cnt_ff <= CNT_W'(NUM_BLOCKS))
   `FCA_ASSERT_NOW(a_alloc_below_want, clock, reset, state_ff == ST_ALLOC_RD,
                   AW'(done_ff) < AW'(want_ff))
   `FCA_ASSERT_NOW(a_write_in_exec, clock, reset, ctl.wr_en,
                   state_ff == ST_ALLOC_EX || state_ff == ST_FREE_EX)
   `FCA_ASSERT_NEXT(a_read_then_exec, clock, reset, ctl.rd_en,
                    state_ff == ST_ALLOC_EX || state_ff == ST_FREE_EX ||
                    state_ff == ST_LOOK_EX)

endmodule
`default_nettype wire

FILE: rtl/fat_chain_allocator.sv
// Top level of the block chain allocator: stream ports and result register.
`default_nettype none
// Keeps a link table and free map for NUM_BLOCKS blocks in one memory and
// serves allocate, free-chain and lookup commands, one item at a time. After
// reset a clearing sweep writes every entry, during which req_tready stays
// low. Each table access is a registered memory read followed by a step that
// updates or captures the entry; allocate scans blocks upward from index 0,
// free walks the chain and lookup reads one entry, while an invalid head or
// unknown command goes straight to the finish step, each then handing its
// item to the output register. The memory port is the limit.
module fat_chain_allocator #(
   parameter int NUM_BLOCKS = fca_pkg::DEF_NUM_BLOCKS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [12:0] block_count, [25:13] chain_head
   input  logic [fca_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [1:0] command
   input  logic [fca_pkg::REQ_TUSER_W-1:0]    req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] status, [13:1] new_head, [26:14] done_count, [39:27] link_value,
   // [52:40] free_total
   output logic [fca_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);
   import fca_pkg::*;

   localparam int IDX_W = $clog2(NUM_BLOCKS);

   tbl_ctl_type        ctl;
   logic [IDX_W-1:0]   tbl_addr;
   logic [IDX_W:0]     wr_link;
   logic               rd_free;
   logic [IDX_W:0]     rd_link;
   logic               clearing;
   logic               res_valid, res_ready;
   logic               status;
   logic [FIELD_W-1:0] new_head, done_count, link_value, free_total;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   fca_table #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .IDX_W      (IDX_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .wr_addr  (tbl_addr),
      .wr_link  (wr_link),
      .rd_addr  (tbl_addr),
      .rd_free  (rd_free),
      .rd_link  (rd_link),
      .clearing (clearing)
   );

   fca_engine #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .IDX_W      (IDX_W)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (req_tvalid),
      .cmd_ready   (req_tready),
      .command     (req_tuser[1:0]),
      .block_count (req_tdata[FIELD_W-1:0]),
      .chain_head  (req_tdata[2*FIELD_W-1:FIELD_W]),
      .ctl         (ctl),
      .tbl_addr    (tbl_addr),
      .wr_link     (wr_link),
      .rd_free     (rd_free),
      .rd_link     (rd_link),
      .clearing    (clearing),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .status      (status),
      .new_head    (new_head),
      .done_count  (done_count),
      .link_value  (link_value),
      .free_total  (free_total)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_TDATA_W'({free_total, link_value, done_count,
                                       new_head, status});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Self-checking stream testbench for the block chain allocator.
`timescale 1ns / 100ps
module tb;
   import fca_pkg::*;

   localparam int NUM_BLOCKS  = fca_pkg::DEF_NUM_BLOCKS;
   localparam int GEN_COPY    = 0;
   localparam int CHK_COPY    = 1;
   localparam int N_RANDOM    = 1080;
   localparam int STALL_LIMIT = 40000;
   localparam int USED_CAP    = 250;
   localparam logic [1:0] CMD_BAD = 2'd3;

   typedef struct {
      logic [1:0]         cmd;
      logic [12:0]        count;
      logic signed [12:0] head;
      int                 gap;
      bit                 drain;
   } fat_req_type;

   typedef struct {
      bit                 status;
      logic signed [12:0] new_head;
      logic [12:0]        done_count;
      logic signed [12:0] link_value;
      logic [12:0]        free_total;
   } fat_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // two copies of the allocator state: one steers stimulus, one checks
   logic signed [12:0] link_mem [2][NUM_BLOCKS];
   bit                 free_bits [2][NUM_BLOCKS];
   int                 free_cnt [2];

   fat_req_type cmd_backlog[$];
   fat_rsp_type owed_rsp[$];
   fat_req_type in_flight;
   int       live_heads[$];
   int       n_items = 0;
   int       items_sent = 0;
   int       results_seen = 0;
   int       err_count = 0;
   int       idle_left = 0;
   int       stall_left = 0;
   bit       long_hold_done = 1'b0;
   int       quiet_cycles = 0;

   fat_chain_allocator #(
      .NUM_BLOCKS(NUM_BLOCKS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void reset_model(int cp);
      for (int i = 0; i < NUM_BLOCKS; i++) begin
         link_mem[cp][i]  = '1;
         free_bits[cp][i] = 1'b1;
      end
      free_cnt[cp] = NUM_BLOCKS;
   endfunction

   function automatic fat_rsp_type apply_command(int cp, fat_req_type it);
      fat_rsp_type r;
      int want, blk, nxt, prev, steps, done, i;
      want = it.count;
      blk  = it.head;
      done = 0;
      prev = -1;
      r.status     = 1'b0;
      r.new_head   = '1;
      r.link_value = '1;
      case (it.cmd)
         CMD_ALLOC: begin
            for (i = 0; i < NUM_BLOCKS && done < want; i++) begin
               if (free_bits[cp][i]) begin
                  link_mem[cp][i]  = 13'(prev);
                  prev             = i;
                  free_bits[cp][i] = 1'b0;
                  free_cnt[cp]--;
                  done++;
               end
            end
            r.new_head = 13'(prev);
            r.status   = done < want;
         end
         CMD_FREE: begin
            if (blk < 0 || blk >= NUM_BLOCKS) begin
               r.status = 1'b1;
            end else begin
               steps = 0;
               while (blk >= 0 && blk < NUM_BLOCKS && steps <= NUM_BLOCKS) begin
                  nxt = link_mem[cp][blk];
                  if (!free_bits[cp][blk]) begin
                     free_bits[cp][blk] = 1'b1;
                     free_cnt[cp]++;
                     done++;
                  end
                  link_mem[cp][blk] = '1;
                  blk = nxt;
                  steps++;
               end
            end
         end
         CMD_LOOKUP: begin
            if (blk < 0 || blk >= NUM_BLOCKS) r.status = 1'b1;
            else r.link_value = link_mem[cp][blk];
         end
         default: begin
            r.status = 1'b1;
         end
      endcase
      r.done_count = 13'(done);
      r.free_total = 13'(free_cnt[cp]);
      return r;
   endfunction

   // steering copy tracks chain heads so frees mostly hit real chains
   function automatic void queue_item(logic [1:0] cmd, int count, int head, bit idle_ok,
                                      bit drain);
      fat_req_type it;
      fat_rsp_type r;
      it.cmd   = cmd;
      it.count = 13'(count);
      it.head  = 13'(head);
      it.drain = drain;
      it.gap   = (idle_ok && $urandom_range(0, 99) < 30) ? $urandom_range(1, 10) : 0;
      r = apply_command(GEN_COPY, it);
      if (cmd == CMD_ALLOC && r.new_head != -1) live_heads.push_back(r.new_head);
      cmd_backlog.push_back(it);
   endfunction

   function automatic void check_field(string name, logic signed [31:0] want,
                                       logic signed [31:0] got);
      if (got !== want) begin
         err_count++;
         $error("%s: expected %0d, actual %0d", name, want, got);
      end
   endfunction

   always @(posedge clock) begin : drive_proc
      fat_req_type nx;
      logic offer;
      logic [REQ_TDATA_W-1:0] word;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
      end else begin
         offer = req_tvalid;
         if (req_tvalid && req_tready) begin
            owed_rsp.push_back(apply_command(CHK_COPY, in_flight));
            items_sent++;
            offer = 1'b0;
            if (cmd_backlog.size() != 0) idle_left = cmd_backlog[0].gap;
         end
         if (!offer && cmd_backlog.size() != 0) begin
            if (idle_left > 0) begin
               idle_left--;
            end else if (!cmd_backlog[0].drain || owed_rsp.size() == 0) begin
               nx = cmd_backlog.pop_front();
               in_flight = nx;
               word = '0;
               word[12:0]  = nx.count;
               word[25:13] = nx.head;
               req_tdata <= word;
               req_tuser <= nx.cmd;
               offer = 1'b1;
            end
         end
         req_tvalid <= offer;
      end
   end

   always @(posedge clock) begin : collect_proc
      fat_rsp_type want_r;
      logic rdy;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (owed_rsp.size() == 0) begin
               err_count++;
               $error("result item with nothing expected");
            end else begin
               want_r = owed_rsp.pop_front();
               check_field("status", want_r.status, rsp_tdata[0]);
               check_field("new_head", want_r.new_head, $signed(rsp_tdata[13:1]));
               check_field("done_count", want_r.done_count, rsp_tdata[26:14]);
               check_field("link_value", want_r.link_value, $signed(rsp_tdata[39:27]));
               check_field("free_total", want_r.free_total, rsp_tdata[52:40]);
            end
         end
         // one long back-pressure stretch to fill the block
         if (!long_hold_done && results_seen >= 400) begin
            long_hold_done = 1'b1;
            stall_left = 600;
         end
         if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
         end else begin
            rdy = 1'b1;
            if (results_seen < n_items - 100 && (results_seen / 150) % 3 != 1 &&
                $urandom_range(0, 99) < 12) begin
               stall_left = $urandom_range(0, 9);
               rdy = 1'b0;
            end
         end
         rsp_tready <= rdy;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stim_proc
      int i, roll, pick, cnt, hd, k, used;
      bit idle_ok;
      reset_model(GEN_COPY);
      reset_model(CHK_COPY);

      // directed: edges of the fields, every command, full and empty table
      queue_item(CMD_LOOKUP, 0, 0, 1, 0);
      queue_item(CMD_LOOKUP, 0, NUM_BLOCKS - 1, 1, 0);
      queue_item(CMD_LOOKUP, 0, -1, 1, 0);
      queue_item(CMD_LOOKUP, 0, -4096, 1, 0);
      queue_item(CMD_FREE, 0, -1, 1, 0);
      queue_item(CMD_FREE, 0, 0, 1, 0);
      queue_item(CMD_BAD, 8191, -1, 1, 0);
      queue_item(CMD_ALLOC, 0, 0, 1, 0);
      queue_item(CMD_ALLOC, NUM_BLOCKS, 0, 1, 0);
      queue_item(CMD_ALLOC, 1, 0, 1, 0);
      queue_item(CMD_LOOKUP, 0, NUM_BLOCKS - 1, 1, 0);
      queue_item(CMD_LOOKUP, 0, 0, 1, 0);
      queue_item(CMD_FREE, 0, NUM_BLOCKS - 1, 1, 0);
      queue_item(CMD_ALLOC, 8191, 0, 1, 0);
      queue_item(CMD_FREE, 0, NUM_BLOCKS - 1, 1, 0);
      queue_item(CMD_ALLOC, 3, 0, 1, 0);
      queue_item(CMD_ALLOC, 2, 0, 1, 0);
      queue_item(CMD_FREE, 0, 0, 1, 0);
      queue_item(CMD_FREE, 0, 2, 1, 0);
      queue_item(CMD_LOOKUP, 0, 4, 1, 0);
      queue_item(CMD_FREE, 0, 4, 1, 0);
      live_heads.delete();

      for (i = 0; i < N_RANDOM; i++) begin
         idle_ok = i < N_RANDOM - 100 && (i / 120) % 3 != 1;
         roll = $urandom_range(0, 99);
         used = NUM_BLOCKS - free_cnt[GEN_COPY];
         if (roll < 38 && used < USED_CAP) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) cnt = 0;
            else if (pick < 8) cnt = $urandom_range(9, 60);
            else cnt = $urandom_range(1, 8);
            queue_item(CMD_ALLOC, cnt, $urandom_range(0, 8191), idle_ok, i == 500);
         end else if (roll < 70 && live_heads.size() != 0) begin
            k = $urandom_range(0, live_heads.size() - 1);
            hd = live_heads[k];
            live_heads.delete(k);
            queue_item(CMD_FREE, $urandom_range(0, 8191), hd, idle_ok, i == 500);
         end else if (roll < 88) begin
            if (live_heads.size() != 0 && $urandom_range(0, 1))
               hd = live_heads[$urandom_range(0, live_heads.size() - 1)];
            else
               hd = $urandom_range(0, 300);
            queue_item(CMD_LOOKUP, $urandom_range(0, 8191), hd, idle_ok, i == 500);
         end else if (roll < 94) begin
            // stale or partial chain: may hit blocks that are already free
            queue_item(CMD_FREE, $urandom_range(0, 8191), $urandom_range(0, 300), idle_ok,
                       i == 500);
         end else if (roll < 98) begin
            queue_item($urandom_range(0, 1) ? CMD_FREE : CMD_LOOKUP,
                       $urandom_range(0, 8191), $urandom_range(4096, 8191), idle_ok,
                       i == 500);
         end else begin
            queue_item(CMD_BAD, $urandom_range(0, 8191), $urandom_range(0, 8191), idle_ok,
                       i == 500);
         end
      end
      n_items = cmd_backlog.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      while (items_sent < n_items || owed_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (err_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
